>>> design/pss_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the periodic slot scheduler: register
// indexes, field widths, controller state and controller/datapath structs.
// ---------------------------------------------------------------------------
package pss_pkg;

   localparam int TIME_W     = 48;
   localparam int PERIOD_W   = 16;
   localparam int STEP_W     = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SRC_IDX_W  = 3;
   localparam int TCOUNT_W   = 3;
   localparam int RCOUNT_W   = 4;
   localparam int MASK_W     = 8;
   localparam int MULT_W     = 10;

   localparam logic [MULT_W-1:0]   MS_TO_US = MULT_W'(1000);
   localparam logic [TIME_W-1:0]   TIME_MAX = {TIME_W{1'b1}};
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
   localparam logic [MASK_W-1:0]   MASK_RESET = {MASK_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_TIMED_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_MASK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD0     = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } pss_state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic mul;
      logic add;
      logic emit;
   } pss_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic have;
      logic out_free;
   } pss_sts_type;

endpackage
`default_nettype wire

>>> design/pss_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_ctrl
// Controller of the scheduler: steps one request through scan, period
// multiply, due time update when a timed source wins, and result handoff.
// ---------------------------------------------------------------------------
module pss_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire pss_pkg::pss_sts_type sts,
   output pss_pkg::pss_cmd_type     cmd
);
   import pss_pkg::*;

   pss_state_type state_ff;
   pss_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = sts.have ? ST_ADD : ST_EMIT;
         end
         ST_ADD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/pss_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_dp
// Datapath of the scheduler: control registers, due times, serial
// earliest-due scan, period step multiply, saturating update, round-robin
// pointer and the result register.
// ---------------------------------------------------------------------------
module pss_dp #(
   parameter int TIMED_SLOTS = 4,
   parameter int RR_SLOTS    = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pss_pkg::pss_cmd_type             cmd,
   output pss_pkg::pss_sts_type                  sts,
   input  wire logic                             csr_we,
   input  wire logic [pss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [pss_pkg::TIME_W-1:0]       req_now_us,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_found,
   output logic                                  rsp_from_timed,
   output logic [pss_pkg::SRC_IDX_W-1:0]         rsp_source_index,
   output logic                                  rsp_mandatory
);
   import pss_pkg::*;

   localparam int TW = (TIMED_SLOTS > 1) ? $clog2(TIMED_SLOTS) : 1;
   localparam int RW = (RR_SLOTS > 1) ? $clog2(RR_SLOTS) : 1;
   localparam logic [RCOUNT_W-1:0] RR_MAX = RCOUNT_W'(RR_SLOTS);

   logic [TCOUNT_W-1:0] timed_count_ff;
   logic [RCOUNT_W-1:0] rr_count_ff;
   logic [MASK_W-1:0]   rr_mask_ff;
   logic [PERIOD_W-1:0] period_ff [TIMED_SLOTS];

   logic [TIME_W-1:0]   due_ff [TIMED_SLOTS];
   logic [TIME_W-1:0]   now_ff;
   logic [TW-1:0]       idx_ff;
   logic [TW-1:0]       idx_in;
   logic                have_ff;
   logic                have_in;
   logic [TW-1:0]       best_ff;
   logic [TW-1:0]       best_in;
   logic [TIME_W-1:0]   best_due_ff;
   logic [TIME_W-1:0]   best_due_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [RW-1:0]       ptr_ff;
   logic [RW-1:0]       ptr_in;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic                rsp_timed_ff;
   logic [SRC_IDX_W-1:0] rsp_idx_ff;
   logic                rsp_mand_ff;

   logic [TIME_W-1:0]   due_cur;
   logic                cand;
   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   due_next;
   logic [RCOUNT_W-1:0] nr;
   logic [RW-1:0]       rr_sel;
   logic [RW-1:0]       rr_after;
   logic [RCOUNT_W-1:0] rr_inc;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         timed_count_ff <= '0;
         rr_count_ff    <= '0;
         rr_mask_ff     <= MASK_RESET;
         for (int i = 0; i < TIMED_SLOTS; i++) period_ff[i] <= PERIOD_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_TIMED_COUNT) timed_count_ff <= csr_wdata[TCOUNT_W-1:0];
         if (csr_index == CSR_RR_COUNT)    rr_count_ff    <= csr_wdata[RCOUNT_W-1:0];
         if (csr_index == CSR_RR_MASK)     rr_mask_ff     <= csr_wdata[MASK_W-1:0];
         for (int i = 0; i < TIMED_SLOTS; i++) begin
            if (csr_index == CSR_IDX_W'(CSR_PERIOD0 + CSR_IDX_W'(i))) begin
               period_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // scan of one due time per cycle
   assign due_cur = due_ff[idx_ff];
   assign cand    = ({{(RCOUNT_W-TW){1'b0}}, idx_ff} < RCOUNT_W'(timed_count_ff))
                    && (now_ff >= due_cur)
                    && (!have_ff || (due_cur < best_due_ff));

   assign sts.scan_last = (idx_ff == TW'(TIMED_SLOTS - 1));
   assign sts.have      = have_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      idx_in      = idx_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      best_due_in = best_due_ff;
      if (cmd.start) begin
         idx_in  = '0;
         have_in = 1'b0;
      end else if (cmd.scan) begin
         idx_in = idx_ff + 1'b1;
         if (cand) begin
            have_in     = 1'b1;
            best_in     = idx_ff;
            best_due_in = due_cur;
         end
      end
   end

   assign step_in  = STEP_W'(period_ff[best_ff]) * STEP_W'(MS_TO_US);
   assign sum      = {1'b0, best_due_ff} + (TIME_W+1)'(step_ff);
   assign due_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

   // round-robin fallback
   assign nr       = (rr_count_ff > RR_MAX) ? RR_MAX : rr_count_ff;
   assign rr_sel   = (RCOUNT_W'(ptr_ff) >= nr) ? '0 : ptr_ff;
   assign rr_inc   = RCOUNT_W'(rr_sel) + 1'b1;
   assign rr_after = (rr_inc >= nr) ? '0 : rr_inc[RW-1:0];
   assign ptr_in   = (cmd.emit && !have_ff && (nr != '0)) ? rr_after : ptr_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) now_ff <= req_now_us;
      if (cmd.mul)   step_ff <= step_in;
      best_ff     <= best_in;
      best_due_ff <= best_due_in;
      idx_ff      <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         ptr_ff  <= '0;
         for (int i = 0; i < TIMED_SLOTS; i++) due_ff[i] <= '0;
      end else begin
         have_ff <= have_in;
         ptr_ff  <= ptr_in;
         if (cmd.add) due_ff[best_ff] <= due_next;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (have_ff) begin
            rsp_found_ff <= 1'b1;
            rsp_timed_ff <= 1'b1;
            rsp_idx_ff   <= SRC_IDX_W'(best_ff);
            rsp_mand_ff  <= 1'b1;
         end else if (nr != '0) begin
            rsp_found_ff <= 1'b1;
            rsp_timed_ff <= 1'b0;
            rsp_idx_ff   <= SRC_IDX_W'(rr_sel);
            rsp_mand_ff  <= rr_mask_ff[SRC_IDX_W'(rr_sel)];
         end else begin
            rsp_found_ff <= 1'b0;
            rsp_timed_ff <= 1'b0;
            rsp_idx_ff   <= '0;
            rsp_mand_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_from_timed   = rsp_timed_ff;
   assign rsp_source_index = rsp_idx_ff;
   assign rsp_mandatory    = rsp_mand_ff;

endmodule
`default_nettype wire

>>> design/periodic_slot_scheduler.sv
`default_nettype none
// Operation: after accept, one timed due time is compared per cycle, then a multiply
//   step and, when a timed source wins, a saturating add step update the winner;
//   the result is written to the result register once that register is free.
// Requests: a new request is taken only after the previous result is handed off.
// Reset: synchronous; due times and round-robin pointer clear, registers take defaults.
// ---------------------------------------------------------------------------
// periodic_slot_scheduler
// Picks the source for each free packet slot: earliest due timed source whose due
// time has been reached, else the next round-robin source, else none.
// ---------------------------------------------------------------------------
module periodic_slot_scheduler #(
   parameter int TIMED_SLOTS = 4,
   parameter int RR_SLOTS    = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [pss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pss_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [pss_pkg::TIME_W-1:0]     req_now_us,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_found,
   output logic                                rsp_from_timed,
   output logic [pss_pkg::SRC_IDX_W-1:0]       rsp_source_index,
   output logic                                rsp_mandatory
);
   import pss_pkg::*;

   pss_cmd_type cmd;
   pss_sts_type sts;

   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pss_dp #(
      .TIMED_SLOTS (TIMED_SLOTS),
      .RR_SLOTS    (RR_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_from_timed   (rsp_from_timed),
      .rsp_source_index (rsp_source_index),
      .rsp_mandatory    (rsp_mandatory)
   );

endmodule
`default_nettype wire

>>> design/pss_chk.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_chk
// Port-level checks of the periodic slot scheduler, bound to the top level.
// ---------------------------------------------------------------------------
module pss_chk #(
   parameter int TIMED_SLOTS = 4
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_found,
   input wire logic                           rsp_from_timed,
   input wire logic [pss_pkg::SRC_IDX_W-1:0]  rsp_source_index,
   input wire logic                           rsp_mandatory
);
   import pss_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         !rsp_from_timed && (rsp_source_index == '0) && !rsp_mandatory)
      else $error("empty result carries nonzero fields");

   a_timed_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_timed |->
         rsp_found && rsp_mandatory
         && (rsp_source_index < SRC_IDX_W'(TIMED_SLOTS)))
      else $error("bad timed result");

endmodule

bind periodic_slot_scheduler pss_chk #(.TIMED_SLOTS(TIMED_SLOTS)) u_pss_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_from_timed   (rsp_from_timed),
   .rsp_source_index (rsp_source_index),
   .rsp_mandatory    (rsp_mandatory)
);
`default_nettype wire
